// ----- hw/rtl/hsa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package hsa_pkg;

	localparam logic [2:0] CMD_ALLOC = 3'd0;
	localparam logic [2:0] CMD_FREE  = 3'd1;
	localparam logic [2:0] CMD_CHECK = 3'd2;
	localparam logic [2:0] CMD_READ  = 3'd3;
	localparam logic [2:0] CMD_RESET = 3'd4;

	localparam logic [1:0] STAT_OK        = 2'd0;
	localparam logic [1:0] STAT_NONE_FREE = 2'd1;
	localparam logic [1:0] STAT_NOT_LIVE  = 2'd2;
	localparam logic [1:0] STAT_POS_RANGE = 2'd3;

	typedef struct packed {
		logic we;
		logic hw_clr;
		logic grow;
	} dense_ctl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hsa_sparse_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsa_sparse_ram #(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [AW-1:0] wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [AW-1:0] rdata
);

	logic [AW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/hsa_dense_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module hsa_dense_store
	import hsa_pkg::*;
#(
	parameter int DEPTH = 256,
	parameter int AW = 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire dense_ctl_t    ctl,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [AW-1:0] wdata,
	input  wire logic [AW:0]   lt,
	input  wire logic [AW-1:0] raddr0,
	input  wire logic [AW-1:0] raddr1,
	output logic      [AW-1:0] rdata0,
	output logic      [AW-1:0] rdata1
);

	// Entries at or above the high-water mark have never been written since
	// the last clear and read back as their own index. As the mark passes an
	// entry, that entry is written with its own index.
	logic [AW-1:0] mem [DEPTH];
	logic [AW:0]   hw_q;
	logic [AW-1:0] mem0_q, mem1_q, addr0_q, addr1_q;
	logic          id0_q, id1_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[waddr] <= wdata;
		end else if (ctl.grow && lt == hw_q) begin
			mem[lt[AW-1:0]] <= lt[AW-1:0];
		end
		mem0_q  <= mem[raddr0];
		mem1_q  <= mem[raddr1];
		addr0_q <= raddr0;
		addr1_q <= raddr1;
		id0_q   <= {1'b0, raddr0} >= hw_q;
		id1_q   <= {1'b0, raddr1} >= hw_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hw_q <= '0;
		end else if (ctl.hw_clr) begin
			hw_q <= '0;
		end else if (ctl.grow && lt == hw_q) begin
			hw_q <= hw_q + 1'b1;
		end
	end

	assign rdata0 = id0_q ? addr0_q : mem0_q;
	assign rdata1 = id1_q ? addr1_q : mem1_q;

endmodule

`default_nettype wire

// ----- hw/rtl/dense_sparse_handle_allocator.sv -----
// Handle allocator with a dense array of handles and a sparse array of positions.
// Alloc and read use S_ALLOC and S_READ, reset and unused codes S_MISC; check passes through
// S_LOOK and S_TEST; free adds S_SWAP: sparse read, dense read, then two dense writes.
// One command is in flight at a time; the next beat is taken once the FSM is back in S_IDLE.
// After reset every sparse entry is cleared to zero before the first beat is accepted.
// The reset command clears the count and the high-water mark at once, so no fill pass runs.
`timescale 1ns / 1ps
`default_nettype none

module dense_sparse_handle_allocator
	import hsa_pkg::*;
#(
	parameter int CAPACITY = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [8:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // handle[7:0], position[15:8]
	input  wire logic [2:0]  s_tuser,   // cmd[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata    // handle_out[7:0], live_count[16:8], status[18:17]
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = AW + 1;
	localparam int WW = (CW > 9) ? CW : 9;

	typedef enum logic [2:0] {
		S_IDLE, S_ALLOC, S_READ, S_LOOK, S_TEST, S_SWAP, S_MISC, S_CLEAR
	} state_t;

	state_t        state_q;
	logic [2:0]    cmd_q;
	logic [7:0]    h_q;
	logic          h_ok_q, rd_ok_q;
	logic [AW-1:0] pos_q, p_q, moved_q, clr_q;
	logic [CW-1:0] lt_q, lt_d;
	logic [8:0]    max_q;
	logic          m_tvalid_q;
	logic [23:0]   m_tdata_q;

	logic [WW-1:0] lt_w, lim_w, cap_w, max_w, in_h_w, in_pos_w, h_w, p_w;
	logic          out_free, done, live;
	logic [7:0]    res_h;
	logic [1:0]    res_st;

	dense_ctl_t    dctl;
	logic [AW-1:0] d_waddr, d_wdata, d_raddr0, d_raddr1, d_rdata0, d_rdata1;
	logic          s_we;
	logic [AW-1:0] s_waddr, s_wdata, s_raddr, s_rdata;

	assign lt_w     = WW'(lt_q);
	assign cap_w    = WW'(CAPACITY);
	assign max_w    = WW'(max_q);
	assign lim_w    = (max_w > cap_w) ? cap_w : max_w;
	assign in_h_w   = WW'(s_tdata[7:0]);
	assign in_pos_w = WW'(s_tdata[15:8]);
	assign h_w      = WW'(h_q);
	assign p_w      = WW'(p_q);
	assign out_free = !m_tvalid_q || m_tready;
	assign live     = h_ok_q && (p_w < lt_w) && (WW'(d_rdata0) == h_w);
	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	assign s_raddr  = (state_q == S_IDLE) ? in_h_w[AW-1:0] : h_w[AW-1:0];
	assign d_raddr1 = AW'(lt_q - 1'b1);

	always_comb begin
		unique case (state_q)
			S_IDLE:  d_raddr0 = (s_tuser == CMD_READ) ? in_pos_w[AW-1:0] : lt_q[AW-1:0];
			S_ALLOC: d_raddr0 = lt_q[AW-1:0];
			S_READ:  d_raddr0 = pos_q;
			S_LOOK:  d_raddr0 = s_rdata;
			S_TEST:  d_raddr0 = p_q;
			default: d_raddr0 = p_q;
		endcase
	end

	always_comb begin
		dctl    = '0;
		d_waddr = p_q;
		d_wdata = moved_q;
		s_we    = 1'b0;
		s_waddr = d_rdata1;
		s_wdata = p_q;
		done    = 1'b0;
		res_h   = '0;
		res_st  = STAT_OK;
		lt_d    = lt_q;
		unique case (state_q)
			S_CLEAR: begin
				s_we    = 1'b1;
				s_waddr = clr_q;
				s_wdata = '0;
			end
			S_ALLOC: begin
				if (out_free) begin
					done = 1'b1;
					if (lt_w < lim_w) begin
						s_we      = 1'b1;
						s_waddr   = d_rdata0;
						s_wdata   = lt_q[AW-1:0];
						dctl.grow = 1'b1;
						lt_d      = lt_q + 1'b1;
						res_h     = 8'(d_rdata0);
					end else begin
						res_st = STAT_NONE_FREE;
					end
				end
			end
			S_READ: begin
				if (out_free) begin
					done = 1'b1;
					if (rd_ok_q) begin
						res_h = 8'(d_rdata0);
					end else begin
						res_st = STAT_POS_RANGE;
					end
				end
			end
			S_TEST: begin
				res_h = h_q;
				if (cmd_q == CMD_FREE && live) begin
					dctl.we = 1'b1;
					d_waddr = d_raddr1;
					d_wdata = h_w[AW-1:0];
					s_we    = 1'b1;
					lt_d    = lt_q - 1'b1;
				end else if (out_free) begin
					done = 1'b1;
					res_st = live ? STAT_OK : STAT_NOT_LIVE;
				end
			end
			S_SWAP: begin
				res_h = h_q;
				if (out_free) begin
					done    = 1'b1;
					dctl.we = 1'b1;
				end
			end
			S_MISC: begin
				if (out_free) begin
					done = 1'b1;
					if (cmd_q == CMD_RESET) begin
						lt_d        = '0;
						dctl.hw_clr = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			clr_q      <= '0;
			lt_q       <= '0;
			max_q      <= 9'd256;
			m_tvalid_q <= 1'b0;
			cmd_q      <= CMD_ALLOC;
			h_q        <= '0;
			h_ok_q     <= 1'b0;
			rd_ok_q    <= 1'b0;
			pos_q      <= '0;
			p_q        <= '0;
			moved_q    <= '0;
			m_tdata_q  <= '0;
		end else begin
			if (cfg_we) begin
				max_q <= cfg_wdata;
			end
			lt_q <= lt_d;
			if (done) begin
				m_tvalid_q <= 1'b1;
				m_tdata_q  <= {5'd0, res_st, 9'(lt_d), res_h};
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == AW'(CAPACITY - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (s_tvalid) begin
						cmd_q   <= s_tuser;
						h_q     <= s_tdata[7:0];
						h_ok_q  <= in_h_w < cap_w;
						rd_ok_q <= in_pos_w < lt_w;
						pos_q   <= in_pos_w[AW-1:0];
						unique case (s_tuser) inside
							CMD_ALLOC:            state_q <= S_ALLOC;
							CMD_READ:             state_q <= S_READ;
							CMD_FREE, CMD_CHECK:  state_q <= S_LOOK;
							default:              state_q <= S_MISC;
						endcase
					end
				end
				S_LOOK: begin
					p_q     <= s_rdata;
					state_q <= S_TEST;
				end
				S_TEST: begin
					if (cmd_q == CMD_FREE && live) begin
						moved_q <= d_rdata1;
						state_q <= S_SWAP;
					end else if (done) begin
						state_q <= S_IDLE;
					end
				end
				S_ALLOC, S_READ, S_SWAP, S_MISC: begin
					if (done) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	hsa_sparse_ram #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_sparse (
		.clk(clk),
		.we(s_we),
		.waddr(s_waddr),
		.wdata(s_wdata),
		.raddr(s_raddr),
		.rdata(s_rdata)
	);

	hsa_dense_store #(
		.DEPTH(CAPACITY),
		.AW(AW)
	) u_dense (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(dctl),
		.waddr(d_waddr),
		.wdata(d_wdata),
		.lt(lt_q),
		.raddr0(d_raddr0),
		.raddr1(d_raddr1),
		.rdata0(d_rdata0),
		.rdata1(d_rdata1)
	);

endmodule

`default_nettype wire
